[hdl/azoc_pkg.sv]
// ---------------------------------------------------------------------------
// ADC zero-offset calibration package
// Shared widths, window sizes, register indexes and transfer types.
// ---------------------------------------------------------------------------
package azoc_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int PHASE_WINDOW_LOG2 = 5;
    localparam int BRAKE_WINDOW_LOG2 = 9;
    localparam int PHASE_SUM_W       = SAMPLE_W + PHASE_WINDOW_LOG2;
    localparam int BRAKE_SUM_W       = SAMPLE_W + BRAKE_WINDOW_LOG2;
    localparam int NUM_PHASES        = 3;

    localparam int SETTLE_W      = 8;
    localparam int PHASE_LIMIT_W = 15;
    localparam int BRAKE_LIMIT_W = 16;
    localparam int RETRY_W       = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [SETTLE_W-1:0]      SETTLE_TICKS_RST = 8'd200;
    localparam logic [PHASE_LIMIT_W-1:0] PHASE_LIMIT_RST  = 15'd5120;
    localparam logic [BRAKE_LIMIT_W-1:0] BRAKE_LIMIT_RST  = 16'd3971;
    localparam logic [RETRY_W-1:0]       RETRY_LIMIT_RST  = 4'd5;
    localparam logic [RETRY_W-1:0]       RETRY_MAX        = 4'd15;

    // most negative mean is folded onto its symmetric neighbour
    localparam logic signed [SAMPLE_W-1:0] MEAN_MOST_NEG = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] MEAN_FLOOR    = 16'sh8001;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SETTLE_TICKS = 2'd0,
        CFG_PHASE_LIMIT  = 2'd1,
        CFG_BRAKE_LIMIT  = 2'd2,
        CFG_RETRY_LIMIT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SETTLE_W-1:0]      settle_ticks;
        logic [PHASE_LIMIT_W-1:0] phase_offset_limit;
        logic [BRAKE_LIMIT_W-1:0] brake_offset_limit;
        logic [RETRY_W-1:0]       fault_retry_limit;
    } t_cfg;

    typedef struct packed {
        logic                       drive_idle;
        logic signed [SAMPLE_W-1:0] sample_u;
        logic signed [SAMPLE_W-1:0] sample_v;
        logic signed [SAMPLE_W-1:0] sample_w;
        logic [SAMPLE_W-1:0]        sample_brake;
    } t_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] offset_u;
        logic signed [SAMPLE_W-1:0] offset_v;
        logic signed [SAMPLE_W-1:0] offset_w;
        logic [SAMPLE_W-1:0]        offset_brake;
        logic                       run_enable;
        logic                       phase_offset_fault;
        logic                       brake_short_fault;
        logic                       brake_offset_ok;
    } t_result;

endpackage

[hdl/adc_zero_offset_calibration_unit.sv]
// ---------------------------------------------------------------------------
// ADC zero-offset calibration unit
// Path: an input transfer is captured in the input register, then moves into
//   the result register when that slot is free or being emptied.
// Throughput: one sample set per cycle while i_stall is low.
// Reset (synchronous, active low): registers to default values, all sums,
//   counters, flags and stored offsets cleared, both stages empty.
// ---------------------------------------------------------------------------
module adc_zero_offset_calibration_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [azoc_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [azoc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_drive_idle,
    input  logic signed [azoc_pkg::SAMPLE_W-1:0]   i_sample_u,
    input  logic signed [azoc_pkg::SAMPLE_W-1:0]   i_sample_v,
    input  logic signed [azoc_pkg::SAMPLE_W-1:0]   i_sample_w,
    input  logic [azoc_pkg::SAMPLE_W-1:0]          i_sample_brake,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [azoc_pkg::SAMPLE_W-1:0]   o_offset_u,
    output logic signed [azoc_pkg::SAMPLE_W-1:0]   o_offset_v,
    output logic signed [azoc_pkg::SAMPLE_W-1:0]   o_offset_w,
    output logic [azoc_pkg::SAMPLE_W-1:0]          o_offset_brake,
    output logic                                   o_run_enable,
    output logic                                   o_phase_offset_fault,
    output logic                                   o_brake_short_fault,
    output logic                                   o_brake_offset_ok
);

    azoc_pkg::t_cfg    cfg;
    azoc_pkg::t_item   in_item;
    azoc_pkg::t_item   core_item;
    azoc_pkg::t_result core_result;
    azoc_pkg::t_result out_result;
    logic              item_valid;
    logic              advance;

    assign in_item.drive_idle   = i_drive_idle;
    assign in_item.sample_u     = i_sample_u;
    assign in_item.sample_v     = i_sample_v;
    assign in_item.sample_w     = i_sample_w;
    assign in_item.sample_brake = i_sample_brake;

    azoc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    azoc_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_item       (in_item),
        .i_advance    (advance),
        .o_stall      (o_stall),
        .o_item_valid (item_valid),
        .o_item       (core_item)
    );

    azoc_cal_core u_cal_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (core_item),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    azoc_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_result     (core_result),
        .i_stall      (i_stall),
        .o_advance    (advance),
        .o_valid      (o_valid),
        .o_result     (out_result)
    );

    assign o_offset_u           = out_result.offset_u;
    assign o_offset_v           = out_result.offset_v;
    assign o_offset_w           = out_result.offset_w;
    assign o_offset_brake       = out_result.offset_brake;
    assign o_run_enable         = out_result.run_enable;
    assign o_phase_offset_fault = out_result.phase_offset_fault;
    assign o_brake_short_fault  = out_result.brake_short_fault;
    assign o_brake_offset_ok    = out_result.brake_offset_ok;

endmodule

[hdl/azoc_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Configuration registers
// Write-only register file for settle time, offset limits and retry limit.
// ---------------------------------------------------------------------------
module azoc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [azoc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [azoc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output azoc_pkg::t_cfg                     o_cfg
);

    azoc_pkg::t_cfg r_cfg;
    azoc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (azoc_pkg::t_cfg_idx'(i_cfg_index))
                azoc_pkg::CFG_SETTLE_TICKS: begin
                    n_cfg.settle_ticks = i_cfg_data[azoc_pkg::SETTLE_W-1:0];
                end
                azoc_pkg::CFG_PHASE_LIMIT: begin
                    n_cfg.phase_offset_limit = i_cfg_data[azoc_pkg::PHASE_LIMIT_W-1:0];
                end
                azoc_pkg::CFG_BRAKE_LIMIT: begin
                    n_cfg.brake_offset_limit = i_cfg_data[azoc_pkg::BRAKE_LIMIT_W-1:0];
                end
                azoc_pkg::CFG_RETRY_LIMIT: begin
                    n_cfg.fault_retry_limit = i_cfg_data[azoc_pkg::RETRY_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks       <= azoc_pkg::SETTLE_TICKS_RST;
            r_cfg.phase_offset_limit <= azoc_pkg::PHASE_LIMIT_RST;
            r_cfg.brake_offset_limit <= azoc_pkg::BRAKE_LIMIT_RST;
            r_cfg.fault_retry_limit  <= azoc_pkg::RETRY_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/azoc_in_stage.sv]
// ---------------------------------------------------------------------------
// Input register
// Holds one sample set until the calibration core takes it.
// ---------------------------------------------------------------------------
module azoc_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  azoc_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_stall,
    output logic            o_item_valid,
    output azoc_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    azoc_pkg::t_item r_item;
    logic            accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

[hdl/azoc_cal_core.sv]
// ---------------------------------------------------------------------------
// Calibration core
// Settle counter, window accumulators, mean checks and stored offsets;
// one state update per sample set.
// ---------------------------------------------------------------------------
module azoc_cal_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  azoc_pkg::t_item   i_item,
    input  azoc_pkg::t_cfg    i_cfg,
    output azoc_pkg::t_result o_result
);

    localparam int PSW = azoc_pkg::PHASE_SUM_W;
    localparam int BSW = azoc_pkg::BRAKE_SUM_W;
    localparam int SW  = azoc_pkg::SAMPLE_W;
    localparam int NP  = azoc_pkg::NUM_PHASES;

    logic [azoc_pkg::SETTLE_W-1:0]            r_settle, n_settle;
    logic signed [PSW-1:0]                    r_phase_sum [NP];
    logic signed [PSW-1:0]                    n_phase_sum [NP];
    logic [azoc_pkg::PHASE_WINDOW_LOG2-1:0]   r_phase_cnt, n_phase_cnt;
    logic [BSW-1:0]                           r_brake_sum, n_brake_sum;
    logic [azoc_pkg::BRAKE_WINDOW_LOG2-1:0]   r_brake_cnt, n_brake_cnt;
    logic signed [SW-1:0]                     r_offset [NP];
    logic signed [SW-1:0]                     n_offset [NP];
    logic [SW-1:0]                            r_brake_off, n_brake_off;
    logic [azoc_pkg::RETRY_W-1:0]             r_retry, n_retry;
    logic                                     r_brake_ok, n_brake_ok;
    logic                                     r_brake_done, n_brake_done;
    logic                                     r_run, n_run;

    logic signed [SW-1:0]                     sample [NP];
    logic signed [SW-1:0]                     mean [NP];
    logic [SW-1:0]                            mag [NP];
    logic [azoc_pkg::SETTLE_W:0]              settle_inc;
    logic [SW-1:0]                            brake_mean;
    logic                                     phase_good;
    logic                                     phase_fault;
    logic                                     brake_fault;

    assign sample[0] = i_item.sample_u;
    assign sample[1] = i_item.sample_v;
    assign sample[2] = i_item.sample_w;

    always_comb begin
        n_settle     = r_settle;
        n_phase_sum  = r_phase_sum;
        n_phase_cnt  = r_phase_cnt;
        n_brake_sum  = r_brake_sum;
        n_brake_cnt  = r_brake_cnt;
        n_offset     = r_offset;
        n_brake_off  = r_brake_off;
        n_retry      = r_retry;
        n_brake_ok   = r_brake_ok;
        n_brake_done = r_brake_done;
        n_run        = r_run;
        phase_fault  = 1'b0;
        brake_fault  = 1'b0;
        phase_good   = 1'b1;
        settle_inc   = {1'b0, r_settle} + 1'b1;
        brake_mean   = '0;
        for (int i = 0; i < NP; i++) begin
            mean[i] = '0;
            mag[i]  = '0;
        end

        if (i_advance) begin
            if (!i_item.drive_idle) begin
                n_settle = '0;
            end else begin
                if (settle_inc > {1'b0, i_cfg.settle_ticks}) begin
                    settle_inc = {1'b0, i_cfg.settle_ticks};
                end
                n_settle = settle_inc[azoc_pkg::SETTLE_W-1:0];
                if (settle_inc < {1'b0, i_cfg.settle_ticks}) begin
                    // still settling: hold accumulators empty
                    for (int i = 0; i < NP; i++) begin
                        n_phase_sum[i] = '0;
                    end
                    n_phase_cnt = '0;
                    n_brake_sum = '0;
                    n_brake_cnt = '0;
                    n_brake_ok  = 1'b0;
                end else begin
                    for (int i = 0; i < NP; i++) begin
                        n_phase_sum[i] = r_phase_sum[i] + PSW'(sample[i]);
                        // arithmetic shift gives the floor of the mean
                        mean[i] = n_phase_sum[i][PSW-1:azoc_pkg::PHASE_WINDOW_LOG2];
                        if (mean[i] == azoc_pkg::MEAN_MOST_NEG) begin
                            mean[i] = azoc_pkg::MEAN_FLOOR;
                        end
                        mag[i] = mean[i][SW-1] ? SW'(-mean[i]) : SW'(mean[i]);
                        if (mag[i] >= {1'b0, i_cfg.phase_offset_limit}) begin
                            phase_good = 1'b0;
                        end
                    end
                    n_phase_cnt = r_phase_cnt + 1'b1;
                    n_brake_sum = r_brake_sum + BSW'(i_item.sample_brake);
                    n_brake_cnt = r_brake_cnt + 1'b1;
                    brake_mean  = n_brake_sum[BSW-1:azoc_pkg::BRAKE_WINDOW_LOG2];

                    // phase window complete: counter wraps to zero
                    if (r_phase_cnt == '1) begin
                        for (int i = 0; i < NP; i++) begin
                            n_phase_sum[i] = '0;
                        end
                        if (phase_good) begin
                            n_offset = mean;
                            n_retry  = '0;
                            n_run    = 1'b1;
                        end else if (r_retry > i_cfg.fault_retry_limit) begin
                            phase_fault = 1'b1;
                            n_retry     = '0;
                            n_settle    = '0;
                            n_run       = 1'b0;
                        end else if (r_retry != azoc_pkg::RETRY_MAX) begin
                            n_retry = r_retry + 1'b1;
                        end
                    end

                    // brake window complete
                    if (r_brake_cnt == '1) begin
                        n_brake_sum = '0;
                        if (!r_brake_done) begin
                            if (brake_mean < i_cfg.brake_offset_limit) begin
                                n_brake_off  = brake_mean;
                                n_brake_ok   = 1'b1;
                                n_brake_done = 1'b1;
                            end else if (!n_brake_ok) begin
                                brake_fault = 1'b1;
                                n_settle    = '0;
                            end
                        end else begin
                            n_brake_ok = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle     <= '0;
            r_phase_cnt  <= '0;
            r_brake_sum  <= '0;
            r_brake_cnt  <= '0;
            r_brake_off  <= '0;
            r_retry      <= '0;
            r_brake_ok   <= 1'b0;
            r_brake_done <= 1'b0;
            r_run        <= 1'b0;
            for (int i = 0; i < NP; i++) begin
                r_phase_sum[i] <= '0;
                r_offset[i]    <= '0;
            end
        end else begin
            r_settle     <= n_settle;
            r_phase_cnt  <= n_phase_cnt;
            r_brake_sum  <= n_brake_sum;
            r_brake_cnt  <= n_brake_cnt;
            r_brake_off  <= n_brake_off;
            r_retry      <= n_retry;
            r_brake_ok   <= n_brake_ok;
            r_brake_done <= n_brake_done;
            r_run        <= n_run;
            r_phase_sum  <= n_phase_sum;
            r_offset     <= n_offset;
        end
    end

    always_comb begin
        o_result.offset_u           = n_offset[0];
        o_result.offset_v           = n_offset[1];
        o_result.offset_w           = n_offset[2];
        o_result.offset_brake       = n_brake_off;
        o_result.run_enable         = n_run;
        o_result.phase_offset_fault = phase_fault;
        o_result.brake_short_fault  = brake_fault;
        o_result.brake_offset_ok    = n_brake_ok;
    end

endmodule

[hdl/azoc_out_stage.sv]
// ---------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes it; decides when the
// pending sample set moves through the core.
// ---------------------------------------------------------------------------
module azoc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  azoc_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_advance,
    output logic              o_valid,
    output azoc_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    azoc_pkg::t_result r_result;

    // advance a pending set when the result slot is free or being emptied
    assign o_advance = i_item_valid && (!r_valid || !i_stall);

    always_comb begin
        n_valid = r_valid;
        if (o_advance) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[hdl/azoc_checker.sv]
// ---------------------------------------------------------------------------
// Port checker
// Watches the calibration unit's ports for result and reset consistency.
// ---------------------------------------------------------------------------
module azoc_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   o_valid,
    input  logic                                   i_stall,
    input  logic signed [azoc_pkg::SAMPLE_W-1:0]   o_offset_u,
    input  logic signed [azoc_pkg::SAMPLE_W-1:0]   o_offset_v,
    input  logic signed [azoc_pkg::SAMPLE_W-1:0]   o_offset_w,
    input  logic                                   o_run_enable,
    input  logic                                   o_phase_offset_fault,
    input  logic                                   o_brake_short_fault,
    input  logic                                   o_brake_offset_ok
);

    // a phase fault always drops run enable in the same result
    a_fault_drops_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_phase_offset_fault |-> !o_run_enable)
        else $error("phase fault with run enable still set");

    // a brake short never comes with a valid brake offset
    a_short_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_brake_short_fault |-> !o_brake_offset_ok)
        else $error("brake short with brake offset flagged valid");

    // the most negative code is never a stored phase offset
    a_no_most_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_offset_u != azoc_pkg::MEAN_MOST_NEG) &&
                    (o_offset_v != azoc_pkg::MEAN_MOST_NEG) &&
                    (o_offset_w != azoc_pkg::MEAN_MOST_NEG))
        else $error("phase offset holds the most negative code");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_offset_u) &&
                               $stable(o_run_enable) && $stable(o_brake_offset_ok))
        else $error("stalled result changed");

endmodule

bind adc_zero_offset_calibration_unit azoc_checker u_azoc_checker (.*);
